@@ hdl/fpa_pkg.sv @@
// shared types and codes for the fixed-point alu
`default_nettype none
package fpa_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_GT    = 4'd4;
  localparam logic [3:0] OP_LT    = 4'd5;
  localparam logic [3:0] OP_GE    = 4'd6;
  localparam logic [3:0] OP_LE    = 4'd7;
  localparam logic [3:0] OP_EQ    = 4'd8;
  localparam logic [3:0] OP_NE    = 4'd9;
  localparam logic [3:0] OP_MIN   = 4'd10;
  localparam logic [3:0] OP_MAX   = 4'd11;
  localparam logic [3:0] OP_INC   = 4'd12;
  localparam logic [3:0] OP_DEC   = 4'd13;
  localparam logic [3:0] OP_TOINT = 4'd14;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [3:0]                   op;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } fpa_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    logic                         flag;
    logic [1:0]                   status;
  } fpa_rsp_t;

  typedef struct packed {
    logic                         valid;
    logic [3:0]                   op;
    logic                         neg;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         flag;
    logic [1:0]                   status;
  } fpa_side_t;

endpackage
`default_nettype wire

@@ hdl/fpa_div.sv @@
// pipelined restoring divider of magnitudes, one quotient bit per stage, rounded
`default_nettype none
module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic [fpa_pkg::DATA_WIDTH-1:0]            x,
  input  wire logic [fpa_pkg::DATA_WIDTH-1:0]            d,
  output logic      [fpa_pkg::DATA_WIDTH+FRAC_BITS:0]    q
);

  localparam int W  = fpa_pkg::DATA_WIDTH;
  localparam int NB = W + FRAC_BITS;

  logic [NB-1:0] num [NB];
  logic [NB-1:0] quo [NB];
  logic [W-1:0]  rem [NB];
  logic [W-1:0]  dv  [NB];

  genvar k;
  generate
    for (k = 0; k < NB; k++) begin : g_stage
      logic [NB-1:0] n_in;
      logic [NB-1:0] q_in;
      logic [W-1:0]  r_in;
      logic [W-1:0]  d_in;
      logic [W:0]    t;
      logic          ge;
      if (k == 0) begin : g_first
        assign n_in = {x, {FRAC_BITS{1'b0}}};
        assign q_in = '0;
        assign r_in = '0;
        assign d_in = d;
      end else begin : g_next
        assign n_in = num[k-1];
        assign q_in = quo[k-1];
        assign r_in = rem[k-1];
        assign d_in = dv[k-1];
      end
      assign t  = {r_in, n_in[NB-1-k]};
      assign ge = (t >= {1'b0, d_in});
      always_ff @(posedge clk) begin
        if (en) begin
          num[k] <= n_in;
          dv[k]  <= d_in;
          quo[k] <= {q_in[NB-2:0], ge};
          rem[k] <= ge ? W'(t - {1'b0, d_in}) : t[W-1:0];
        end
      end
    end
  endgenerate

  // round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      q <= {1'b0, quo[NB-1]} +
           (NB+1)'({rem[NB-1], 1'b0} >= {1'b0, dv[NB-1]});
    end
  end

endmodule
`default_nettype wire

@@ hdl/fpa_mul.sv @@
// pipelined magnitude multiplier with rounding, padded to the divider latency
`default_nettype none
module fpa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     en,
  input  wire logic [fpa_pkg::DATA_WIDTH-1:0]           x,
  input  wire logic [fpa_pkg::DATA_WIDTH-1:0]           y,
  output logic      [2*fpa_pkg::DATA_WIDTH-FRAC_BITS:0] p
);

  localparam int W   = fpa_pkg::DATA_WIDTH;
  localparam int MW  = 2*W + 1 - FRAC_BITS;
  localparam int LAT = W + FRAC_BITS + 1;
  localparam int PAD = LAT - 2;

  logic [2*W-1:0] prod;
  logic [MW-1:0]  rnd;
  logic [MW-1:0]  pad [PAD];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= {{W{1'b0}}, x} * {{W{1'b0}}, y};
      rnd  <= MW'(({1'b0, prod} + ((2*W+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS);
      pad[0] <= rnd;
    end
  end

  genvar j;
  generate
    for (j = 1; j < PAD; j++) begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          pad[j] <= pad[j-1];
        end
      end
    end
  endgenerate

  assign p = pad[PAD-1];

endmodule
`default_nettype wire

@@ hdl/fixed_point_alu.sv @@
// Signed fixed-point ALU, top level. Takes one word per cycle while the output is
// not stalled and returns one result word per input, in order; the pipeline
// depth is set by the divider, which resolves one quotient bit per pipeline
// stage, and all other operations are delayed to match. A stalled output holds
// the whole pipeline.
`default_nettype none
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire fpa_pkg::fpa_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output fpa_pkg::fpa_rsp_t      rsp
);

  localparam int W   = fpa_pkg::DATA_WIDTH;
  localparam int NB  = W + FRAC_BITS;
  localparam int LAT = NB + 1;
  localparam int MW  = 2*W + 1 - FRAC_BITS;
  localparam int QW  = 2*W + 1;

  logic en;
  logic              v0;
  fpa_pkg::fpa_req_t s0;
  fpa_pkg::fpa_side_t s1_next;
  fpa_pkg::fpa_side_t dl [LAT];
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [NB:0]  div_q;
  logic [MW-1:0] mul_p;
  fpa_pkg::fpa_rsp_t rsp_next;

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= req;
    end
  end

  assign mag_a = s0.operand_a[W-1] ? W'(0 - s0.operand_a) : s0.operand_a;
  assign mag_b = s0.operand_b[W-1] ? W'(0 - s0.operand_b) : s0.operand_b;

  // operations computed directly from the input register, plus divide-by-zero and sign
  always_comb begin
    logic signed [W:0] ax;
    logic signed [W:0] bx;
    logic signed [W:0] s;
    logic              lt_ab;
    logic              lt_ba;
    ax = {s0.operand_a[W-1], s0.operand_a};
    bx = {s0.operand_b[W-1], s0.operand_b};
    lt_ab = s0.operand_a < s0.operand_b;
    lt_ba = s0.operand_b < s0.operand_a;
    s = ax + bx;
    s1_next.valid  = v0;
    s1_next.op     = s0.op;
    s1_next.neg    = s0.operand_a[W-1] ^ s0.operand_b[W-1];
    s1_next.result = '0;
    s1_next.flag   = 1'b0;
    s1_next.status = fpa_pkg::ST_OK;
    case (s0.op)
      fpa_pkg::OP_ADD:   s = ax + bx;
      fpa_pkg::OP_SUB:   s = ax - bx;
      fpa_pkg::OP_INC:   s = ax + (W+1)'(1);
      fpa_pkg::OP_DEC:   s = ax - (W+1)'(1);
      default:           s = ax;
    endcase
    case (s0.op)
      fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
        if (s[W] != s[W-1]) begin
          s1_next.result = s[W] ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
          s1_next.status = fpa_pkg::ST_OVF;
        end else begin
          s1_next.result = s[W-1:0];
        end
      end
      fpa_pkg::OP_DIV: begin
        if (s0.operand_b == '0) begin
          s1_next.status = fpa_pkg::ST_DIVZ;
        end
      end
      fpa_pkg::OP_GT:    s1_next.flag = lt_ba;
      fpa_pkg::OP_LT:    s1_next.flag = lt_ab;
      fpa_pkg::OP_GE:    s1_next.flag = !lt_ab;
      fpa_pkg::OP_LE:    s1_next.flag = !lt_ba;
      fpa_pkg::OP_EQ:    s1_next.flag = (s0.operand_a == s0.operand_b);
      fpa_pkg::OP_NE:    s1_next.flag = (s0.operand_a != s0.operand_b);
      fpa_pkg::OP_MIN:   s1_next.result = lt_ab ? s0.operand_a : s0.operand_b;
      fpa_pkg::OP_MAX:   s1_next.result = lt_ba ? s0.operand_a : s0.operand_b;
      fpa_pkg::OP_TOINT: s1_next.result = s0.operand_a >>> FRAC_BITS;
      default: ;
    endcase
  end

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .x   (mag_a),
    .d   (mag_b),
    .q   (div_q)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .en  (en),
    .x   (mag_a),
    .y   (mag_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dl[0].valid <= 1'b0;
    end else if (en) begin
      dl[0].valid <= s1_next.valid;
    end
    if (en) begin
      dl[0].op     <= s1_next.op;
      dl[0].neg    <= s1_next.neg;
      dl[0].result <= s1_next.result;
      dl[0].flag   <= s1_next.flag;
      dl[0].status <= s1_next.status;
    end
  end

  genvar j;
  generate
    for (j = 1; j < LAT; j++) begin : g_line
      always_ff @(posedge clk) begin
        if (rst) begin
          dl[j].valid <= 1'b0;
        end else if (en) begin
          dl[j].valid <= dl[j-1].valid;
        end
        if (en) begin
          dl[j].op     <= dl[j-1].op;
          dl[j].neg    <= dl[j-1].neg;
          dl[j].result <= dl[j-1].result;
          dl[j].flag   <= dl[j-1].flag;
          dl[j].status <= dl[j-1].status;
        end
      end
    end
  endgenerate

  // sign and saturate the multiply and divide magnitudes
  always_comb begin
    logic [QW-1:0] m;
    logic [QW-1:0] lim;
    fpa_pkg::fpa_side_t t;
    t = dl[LAT-1];
    m = (t.op == fpa_pkg::OP_MUL) ? QW'(mul_p) : QW'(div_q);
    lim = t.neg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
    rsp_next.result = t.result;
    rsp_next.flag   = t.flag;
    rsp_next.status = t.status;
    if ((t.op == fpa_pkg::OP_MUL) ||
        (t.op == fpa_pkg::OP_DIV && t.status != fpa_pkg::ST_DIVZ)) begin
      if (m > lim) begin
        rsp_next.result = t.neg ? fpa_pkg::MIN_VAL : fpa_pkg::MAX_VAL;
        rsp_next.status = fpa_pkg::ST_OVF;
      end else begin
        rsp_next.result = t.neg ? W'(0 - m) : m[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= dl[LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == fpa_pkg::ST_DIVZ |-> rsp.result == '0 && !rsp.flag)
    else $error("divide by zero word with nonzero result");
  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.flag |-> rsp.result == '0 && rsp.status == fpa_pkg::ST_OK)
    else $error("compare word with result or status");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != 2'd3)
    else $error("undefined status code");
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without output backpressure");
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == fpa_pkg::ST_OVF |->
      rsp.result == fpa_pkg::MAX_VAL || rsp.result == fpa_pkg::MIN_VAL)
    else $error("overflow word not saturated");
`endif

endmodule
`default_nettype wire
